>>> hw/rtl/grsf_pkg.sv
// Shared types, codes and arithmetic helpers for the grid region slope flood fill unit.
// Used by grsf_cell_store and grid_region_slope_flood_fill_unit; depends on nothing.
package grsf_pkg;

  localparam int unsigned MAX_CELLS_DEF = 4096;
  localparam int unsigned MAX_SIDE_DEF  = 64;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [2:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_SMOOTH_THR  = 3'd2;
  localparam logic [2:0] CFG_HEIGHT_THR  = 3'd3;
  localparam logic [2:0] CFG_MIN_REGION  = 3'd4;

  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  localparam logic        KIND_RUN  = 1'b0;
  localparam logic        KIND_READ = 1'b1;

  localparam logic [6:0]  RST_GRID_WIDTH  = 7'd64;
  localparam logic [6:0]  RST_GRID_HEIGHT = 7'd64;
  localparam logic [30:0] RST_SMOOTH_THR  = 31'd19661;
  localparam logic [30:0] RST_HEIGHT_THR  = 31'd655294464;
  localparam logic [12:0] RST_MIN_REGION  = 13'd50;
  localparam logic [12:0] SNAP_MAX        = 13'h1FFF;

  typedef struct packed {
    logic [1:0]         op;
    logic [11:0]        cell_index;
    logic signed [31:0] terrain_height;
    logic signed [31:0] cloth_height;
    logic               movable;
  } in_word_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] cell_height;
    logic               cell_movable;
    logic [12:0]        snapped_count;
  } out_word_t;

  // One entry of the cell store: heights, movable mark and the three scan flags.
  typedef struct packed {
    logic signed [31:0] terrain;
    logic signed [31:0] cloth;
    logic               movable;
    logic               seen;
    logic               member;
    logic               sseen;
  } cell_data_t;

  typedef struct packed {
    logic terrain;
    logic cloth;
    logic movable;
    logic seen;
    logic member;
    logic sseen;
  } cell_wen_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_READ, ST_SIZE, ST_CLEAR,
    ST_SCAN_RD, ST_SCAN_CHK, ST_SCAN_NEXT,
    ST_GATHER_POP, ST_GATHER_LD, ST_GATHER_NB, ST_GATHER_NCHK,
    ST_EDGE_POP, ST_EDGE_LD, ST_EDGE_CUR, ST_EDGE_NB, ST_EDGE_NCHK,
    ST_SPREAD_POP, ST_SPREAD_LD, ST_SPREAD_CUR, ST_SPREAD_NB, ST_SPREAD_NCHK,
    ST_CLR_POP, ST_CLR_WR, ST_DONE
  } state_e;

  // |a - b| < thr, exact over the 33-bit difference.
  function automatic logic abs_below(logic signed [31:0] a, logic signed [31:0] b,
                                     logic [30:0] thr);
    logic signed [32:0] df;
    logic [32:0]        mag;
    df  = {a[31], a} - {b[31], b};
    mag = df[32] ? 33'(-df) : 33'(df);
    return mag < {2'b00, thr};
  endfunction

  // (a - b) < thr as signed values.
  function automatic logic signed_below(logic signed [31:0] a, logic signed [31:0] b,
                                        logic [30:0] thr);
    logic signed [32:0] df;
    df = {a[31], a} - {b[31], b};
    return $signed({df[32], df}) < $signed({3'b000, thr});
  endfunction

endpackage

>>> hw/rtl/grsf_cell_store.sv
// Cell store of the flood fill unit: heights, movable marks and scan flags per cell.
// Uses grsf_pkg for the entry and write-enable types.
module grsf_cell_store #(
  parameter int unsigned MAX_CELLS = grsf_pkg::MAX_CELLS_DEF
) (
  input  logic                         clk_i,
  input  logic [$clog2(MAX_CELLS)-1:0] raddr_i,
  input  logic [$clog2(MAX_CELLS)-1:0] waddr_i,
  input  grsf_pkg::cell_wen_t          wen_i,
  input  grsf_pkg::cell_data_t         wdata_i,
  output grsf_pkg::cell_data_t         rdata_o
);

  logic [31:0] terrain_mem [MAX_CELLS];
  logic [31:0] cloth_mem   [MAX_CELLS];
  logic        movable_mem [MAX_CELLS];
  logic        seen_mem    [MAX_CELLS];
  logic        member_mem  [MAX_CELLS];
  logic        sseen_mem   [MAX_CELLS];

  always_ff @(posedge clk_i) begin
    if (wen_i.terrain) terrain_mem[waddr_i] <= wdata_i.terrain;
    if (wen_i.cloth)   cloth_mem[waddr_i]   <= wdata_i.cloth;
    if (wen_i.movable) movable_mem[waddr_i] <= wdata_i.movable;
    if (wen_i.seen)    seen_mem[waddr_i]    <= wdata_i.seen;
    if (wen_i.member)  member_mem[waddr_i]  <= wdata_i.member;
    if (wen_i.sseen)   sseen_mem[waddr_i]   <= wdata_i.sseen;
  end

  // Registered read, old data on a same-address write in the same cycle.
  always_ff @(posedge clk_i) begin
    rdata_o.terrain <= terrain_mem[raddr_i];
    rdata_o.cloth   <= cloth_mem[raddr_i];
    rdata_o.movable <= movable_mem[raddr_i];
    rdata_o.seen    <= seen_mem[raddr_i];
    rdata_o.member  <= member_mem[raddr_i];
    rdata_o.sseen   <= sseen_mem[raddr_i];
  end

endmodule

>>> hw/rtl/grid_region_slope_flood_fill_unit.sv
// Top level of the grid region slope flood fill unit: sequencer, lists and result register.
// Depends on grsf_pkg and grsf_cell_store.
//
//  channel   direction  handshake                 word
//  request   in         start high, busy low      req_i   (grsf_pkg::in_word_t)
//  result    out        result_valid_o, 1 cycle   result_o (grsf_pkg::out_word_t)
//  config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A load word is written in the cycle it is accepted and busy stays low, so loads
// go at one per cycle. A read word passes through the registered cell store read
// port and then the ST_READ and ST_DONE states. A run word first settles the grid
// height, then sweeps every one of the MAX_CELLS store entries to clear the scan flags,
// then scans the grid, reading and writing the cell store and lists as it goes.
// Reset clears the sequencer, counters and configuration; the stores hold no reset.
// The receiver cannot stall: each result word is shown for exactly one cycle.
module grid_region_slope_flood_fill_unit #(
  parameter int unsigned MAX_CELLS = grsf_pkg::MAX_CELLS_DEF,
  parameter int unsigned MAX_SIDE  = grsf_pkg::MAX_SIDE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  grsf_pkg::in_word_t  req_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [30:0]         cfg_data_i,
  output logic                result_valid_o,
  output grsf_pkg::out_word_t result_o
);

  localparam int unsigned AW = $clog2(MAX_CELLS);
  localparam int unsigned SW = $clog2(MAX_SIDE);
  localparam int unsigned WW = $clog2(MAX_SIDE + 1);
  localparam int unsigned CW = $clog2(MAX_CELLS + 1);
  localparam int unsigned LW = AW + 2 * SW;

  // Configuration registers.
  logic [6:0]  gw_q, gh_q;
  logic [30:0] smooth_q, hthr_q;
  logic [12:0] minreg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q     <= grsf_pkg::RST_GRID_WIDTH;
      gh_q     <= grsf_pkg::RST_GRID_HEIGHT;
      smooth_q <= grsf_pkg::RST_SMOOTH_THR;
      hthr_q   <= grsf_pkg::RST_HEIGHT_THR;
      minreg_q <= grsf_pkg::RST_MIN_REGION;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        grsf_pkg::CFG_GRID_WIDTH:  gw_q     <= cfg_data_i[6:0];
        grsf_pkg::CFG_GRID_HEIGHT: gh_q     <= cfg_data_i[6:0];
        grsf_pkg::CFG_SMOOTH_THR:  smooth_q <= cfg_data_i;
        grsf_pkg::CFG_HEIGHT_THR:  hthr_q   <= cfg_data_i;
        grsf_pkg::CFG_MIN_REGION:  minreg_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  grsf_pkg::state_e   state_q, state_d;
  logic [WW-1:0]      w_q, w_d, h_q, h_d;
  logic [AW-1:0]      sweep_q, sweep_d;
  logic [SW-1:0]      sx_q, sx_d, sy_q, sy_d;
  logic [AW-1:0]      sc_q, sc_d;
  logic [CW-1:0]      head_q, head_d, count_q, count_d, tail_q, tail_d;
  logic [1:0]         dir_q, dir_d;
  logic [AW-1:0]      cur_c_q, cur_c_d, nb_c_q, nb_c_d;
  logic [SW-1:0]      cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [31:0] cur_t_q, cur_t_d;
  logic               cur_m_q, cur_m_d, above_q, above_d, oor_q, oor_d;
  logic [12:0]        snap_q, snap_d;
  logic               rv_q, rv_d;
  grsf_pkg::out_word_t res_q, res_d;
  logic [SW-1:0]      nb_x_q, nb_x_d, nb_y_q, nb_y_d;

  // Stores.
  logic [AW-1:0]        cell_raddr, cell_waddr;
  grsf_pkg::cell_wen_t  cell_wen;
  grsf_pkg::cell_data_t cell_wdata, cr;

  grsf_cell_store #(.MAX_CELLS(MAX_CELLS)) u_store (
    .clk_i   (clk_i),
    .raddr_i (cell_raddr),
    .waddr_i (cell_waddr),
    .wen_i   (cell_wen),
    .wdata_i (cell_wdata),
    .rdata_o (cr)
  );

  // Region list and spread queue; an entry holds {cell, column, row}.
  logic [LW-1:0] rl_mem [MAX_CELLS];
  logic [LW-1:0] sq_mem [MAX_CELLS];
  logic [LW-1:0] rl_rd, sq_rd, rl_wdata, sq_wdata;
  logic [AW-1:0] rl_raddr, rl_waddr, sq_raddr, sq_waddr;
  logic          rl_we, sq_we;

  always_ff @(posedge clk_i) begin
    if (rl_we) rl_mem[rl_waddr] <= rl_wdata;
    if (sq_we) sq_mem[sq_waddr] <= sq_wdata;
    rl_rd <= rl_mem[rl_raddr];
    sq_rd <= sq_mem[sq_raddr];
  end

  // Unpacked list read data.
  logic [AW-1:0] rl_c, sq_c;
  logic [SW-1:0] rl_x, rl_y, sq_x, sq_y;
  assign {rl_c, rl_x, rl_y} = rl_rd;
  assign {sq_c, sq_x, sq_y} = sq_rd;

  // Neighbour of the current cell in the current direction.
  logic          nb_ok;
  logic [AW-1:0] nb_c_w;
  logic [SW-1:0] nb_x_w, nb_y_w;

  always_comb begin
    nb_ok  = 1'b0;
    nb_c_w = cur_c_q;
    nb_x_w = cur_x_q;
    nb_y_w = cur_y_q;
    case (dir_q)
      grsf_pkg::DIR_LEFT: begin
        nb_ok  = (cur_x_q != '0);
        nb_c_w = cur_c_q - AW'(1);
        nb_x_w = cur_x_q - SW'(1);
      end
      grsf_pkg::DIR_RIGHT: begin
        nb_ok  = (32'(cur_x_q) + 32'd1 < 32'(w_q));
        nb_c_w = cur_c_q + AW'(1);
        nb_x_w = cur_x_q + SW'(1);
      end
      grsf_pkg::DIR_UP: begin
        nb_ok  = (cur_y_q != '0);
        nb_c_w = cur_c_q - AW'(w_q);
        nb_y_w = cur_y_q - SW'(1);
      end
      grsf_pkg::DIR_DOWN: begin
        nb_ok  = (32'(cur_y_q) + 32'd1 < 32'(h_q));
        nb_c_w = cur_c_q + AW'(w_q);
        nb_y_w = cur_y_q + SW'(1);
      end
      default: ;
    endcase
  end

  // Decision terms on the store read data.
  logic idx_ok, is_load, take_scan, take_nb, close_w, edge_hit, spread_hit;
  logic scan_last, dir_last, region_big, size_over;
  logic [12:0] snap_inc;
  logic [31:0] w_cfg, h_cfg;

  assign idx_ok     = (32'(req_i.cell_index) < MAX_CELLS);
  assign is_load    = start && (req_i.op == grsf_pkg::OP_LOAD) && idx_ok;
  assign take_scan  = cr.movable && !cr.seen;
  assign take_nb    = cr.movable && !cr.seen;
  assign close_w    = grsf_pkg::abs_below(cur_t_q, cr.terrain, smooth_q);
  assign edge_hit   = !cr.movable && close_w && above_q;
  assign spread_hit = cr.member && close_w &&
                      grsf_pkg::abs_below(cr.cloth, cr.terrain, hthr_q);
  assign scan_last  = (32'(sy_q) + 32'd1 >= 32'(h_q)) && (32'(sx_q) + 32'd1 >= 32'(w_q));
  assign dir_last   = (dir_q == grsf_pkg::DIR_DOWN);
  assign region_big = (32'(count_q) > 32'(minreg_q));
  assign size_over  = (32'(w_q) * 32'(h_q) > MAX_CELLS);
  assign snap_inc   = (snap_q == grsf_pkg::SNAP_MAX) ? snap_q : snap_q + 13'd1;

  // Grid size from the registers, clamped to 1 .. MAX_SIDE.
  assign w_cfg = (gw_q == '0) ? 32'd1 : ((32'(gw_q) > MAX_SIDE) ? MAX_SIDE : 32'(gw_q));
  assign h_cfg = (gh_q == '0) ? 32'd1 : ((32'(gh_q) > MAX_SIDE) ? MAX_SIDE : 32'(gh_q));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      grsf_pkg::ST_IDLE: begin
        if (start) begin
          case (req_i.op)
            grsf_pkg::OP_RUN:  state_d = grsf_pkg::ST_SIZE;
            grsf_pkg::OP_READ: state_d = grsf_pkg::ST_READ;
            default:           state_d = grsf_pkg::ST_IDLE;
          endcase
        end
      end
      grsf_pkg::ST_READ: state_d = grsf_pkg::ST_DONE;
      grsf_pkg::ST_SIZE: begin
        if (h_q == '0)      state_d = grsf_pkg::ST_DONE;
        else if (!size_over) state_d = grsf_pkg::ST_CLEAR;
      end
      grsf_pkg::ST_CLEAR: begin
        if (sweep_q == AW'(MAX_CELLS - 1)) state_d = grsf_pkg::ST_SCAN_RD;
      end
      grsf_pkg::ST_SCAN_RD:  state_d = grsf_pkg::ST_SCAN_CHK;
      grsf_pkg::ST_SCAN_CHK: state_d = take_scan ? grsf_pkg::ST_GATHER_POP
                                                 : grsf_pkg::ST_SCAN_NEXT;
      grsf_pkg::ST_SCAN_NEXT: state_d = scan_last ? grsf_pkg::ST_DONE : grsf_pkg::ST_SCAN_RD;
      grsf_pkg::ST_GATHER_POP: begin
        if (head_q < count_q) state_d = grsf_pkg::ST_GATHER_LD;
        else if (region_big)  state_d = grsf_pkg::ST_EDGE_POP;
        else                  state_d = grsf_pkg::ST_CLR_POP;
      end
      grsf_pkg::ST_GATHER_LD: state_d = grsf_pkg::ST_GATHER_NB;
      grsf_pkg::ST_GATHER_NB: begin
        if (nb_ok)         state_d = grsf_pkg::ST_GATHER_NCHK;
        else if (dir_last) state_d = grsf_pkg::ST_GATHER_POP;
      end
      grsf_pkg::ST_GATHER_NCHK: state_d = dir_last ? grsf_pkg::ST_GATHER_POP
                                                   : grsf_pkg::ST_GATHER_NB;
      grsf_pkg::ST_EDGE_POP: state_d = (head_q < count_q) ? grsf_pkg::ST_EDGE_LD
                                                          : grsf_pkg::ST_SPREAD_POP;
      grsf_pkg::ST_EDGE_LD:  state_d = grsf_pkg::ST_EDGE_CUR;
      grsf_pkg::ST_EDGE_CUR: state_d = grsf_pkg::ST_EDGE_NB;
      grsf_pkg::ST_EDGE_NB: begin
        if (nb_ok)         state_d = grsf_pkg::ST_EDGE_NCHK;
        else if (dir_last) state_d = grsf_pkg::ST_EDGE_POP;
      end
      grsf_pkg::ST_EDGE_NCHK: state_d = (edge_hit || dir_last) ? grsf_pkg::ST_EDGE_POP
                                                               : grsf_pkg::ST_EDGE_NB;
      grsf_pkg::ST_SPREAD_POP: state_d = (head_q < tail_q) ? grsf_pkg::ST_SPREAD_LD
                                                           : grsf_pkg::ST_CLR_POP;
      grsf_pkg::ST_SPREAD_LD:  state_d = grsf_pkg::ST_SPREAD_CUR;
      grsf_pkg::ST_SPREAD_CUR: state_d = grsf_pkg::ST_SPREAD_NB;
      grsf_pkg::ST_SPREAD_NB: begin
        if (nb_ok)         state_d = grsf_pkg::ST_SPREAD_NCHK;
        else if (dir_last) state_d = grsf_pkg::ST_SPREAD_POP;
      end
      grsf_pkg::ST_SPREAD_NCHK: state_d = dir_last ? grsf_pkg::ST_SPREAD_POP
                                                   : grsf_pkg::ST_SPREAD_NB;
      grsf_pkg::ST_CLR_POP: state_d = (head_q < count_q) ? grsf_pkg::ST_CLR_WR
                                                         : grsf_pkg::ST_SCAN_NEXT;
      grsf_pkg::ST_CLR_WR: state_d = grsf_pkg::ST_CLR_POP;
      grsf_pkg::ST_DONE:   state_d = grsf_pkg::ST_IDLE;
      default:             state_d = grsf_pkg::ST_IDLE;
    endcase
  end

  // Datapath register updates.
  always_comb begin
    w_d = w_q; h_d = h_q; sweep_d = sweep_q;
    sx_d = sx_q; sy_d = sy_q; sc_d = sc_q;
    head_d = head_q; count_d = count_q; tail_d = tail_q; dir_d = dir_q;
    cur_c_d = cur_c_q; cur_x_d = cur_x_q; cur_y_d = cur_y_q;
    nb_c_d = nb_c_q; nb_x_d = nb_x_q; nb_y_d = nb_y_q;
    cur_t_d = cur_t_q; cur_m_d = cur_m_q; above_d = above_q; oor_d = oor_q;
    snap_d = snap_q;
    rv_d = 1'b0;
    res_d = res_q;
    case (state_q)
      grsf_pkg::ST_IDLE: begin
        if (start && (req_i.op == grsf_pkg::OP_RUN)) begin
          w_d = WW'(w_cfg);
          h_d = WW'(h_cfg);
        end
        oor_d = !idx_ok;
      end
      grsf_pkg::ST_READ: begin
        res_d.result_kind   = grsf_pkg::KIND_READ;
        res_d.cell_height   = oor_q ? 32'sd0 : cr.cloth;
        res_d.cell_movable  = oor_q ? 1'b0 : cr.movable;
        res_d.snapped_count = '0;
      end
      grsf_pkg::ST_SIZE: begin
        // A grid wider than the store leaves no rows; the count is kept.
        if (h_q != '0) begin
          if (size_over) h_d = h_q - WW'(1);
          else begin
            sweep_d = '0;
            snap_d  = '0;
          end
        end
        sx_d = '0; sy_d = '0; sc_d = '0;
        res_d.result_kind   = grsf_pkg::KIND_RUN;
        res_d.cell_height   = 32'sd0;
        res_d.cell_movable  = 1'b0;
      end
      grsf_pkg::ST_CLEAR: sweep_d = sweep_q + AW'(1);
      grsf_pkg::ST_SCAN_CHK: begin
        if (take_scan) begin
          head_d  = '0;
          count_d = CW'(1);
        end
      end
      grsf_pkg::ST_SCAN_NEXT: begin
        // Column outer, row inner.
        if (32'(sy_q) + 32'd1 < 32'(h_q)) begin
          sy_d = sy_q + SW'(1);
          sc_d = sc_q + AW'(w_q);
        end else begin
          sy_d = '0;
          sx_d = sx_q + SW'(1);
          sc_d = AW'(sx_q) + AW'(1);
        end
      end
      grsf_pkg::ST_GATHER_POP: begin
        if (!(head_q < count_q)) begin
          head_d = '0;
          tail_d = '0;
        end
      end
      grsf_pkg::ST_GATHER_LD, grsf_pkg::ST_EDGE_LD: begin
        cur_c_d = rl_c; cur_x_d = rl_x; cur_y_d = rl_y;
        head_d  = head_q + CW'(1);
        dir_d   = grsf_pkg::DIR_LEFT;
      end
      grsf_pkg::ST_SPREAD_LD: begin
        cur_c_d = sq_c; cur_x_d = sq_x; cur_y_d = sq_y;
        head_d  = head_q + CW'(1);
        dir_d   = grsf_pkg::DIR_LEFT;
      end
      grsf_pkg::ST_GATHER_NB, grsf_pkg::ST_EDGE_NB, grsf_pkg::ST_SPREAD_NB: begin
        nb_c_d = nb_c_w; nb_x_d = nb_x_w; nb_y_d = nb_y_w;
        if (!nb_ok) dir_d = dir_q + 2'd1;
      end
      grsf_pkg::ST_GATHER_NCHK: begin
        if (take_nb) count_d = count_q + CW'(1);
        dir_d = dir_q + 2'd1;
      end
      grsf_pkg::ST_EDGE_POP: begin
        if (!(head_q < count_q)) head_d = '0;
      end
      grsf_pkg::ST_EDGE_CUR: begin
        cur_t_d = cr.terrain;
        cur_m_d = cr.movable;
        above_d = grsf_pkg::signed_below(cr.cloth, cr.terrain, hthr_q);
      end
      grsf_pkg::ST_EDGE_NCHK: begin
        if (edge_hit) begin
          tail_d = tail_q + CW'(1);
          if (cur_m_q) snap_d = snap_inc;
        end
        dir_d = dir_q + 2'd1;
      end
      grsf_pkg::ST_SPREAD_POP: begin
        if (!(head_q < tail_q)) head_d = '0;
      end
      grsf_pkg::ST_SPREAD_CUR: cur_t_d = cr.terrain;
      grsf_pkg::ST_SPREAD_NCHK: begin
        if (spread_hit) begin
          if (cr.movable) snap_d = snap_inc;
          if (!cr.sseen)  tail_d = tail_q + CW'(1);
        end
        dir_d = dir_q + 2'd1;
      end
      grsf_pkg::ST_CLR_WR: head_d = head_q + CW'(1);
      grsf_pkg::ST_DONE: begin
        rv_d = 1'b1;
        if (res_q.result_kind == grsf_pkg::KIND_RUN) res_d.snapped_count = snap_q;
      end
      default: ;
    endcase
  end

  // Store and list port control.
  always_comb begin
    cell_raddr = sc_q;
    cell_waddr = nb_c_q;
    cell_wen   = '0;
    cell_wdata.terrain = req_i.terrain_height;
    cell_wdata.cloth   = req_i.cloth_height;
    cell_wdata.movable = 1'b0;
    cell_wdata.seen    = 1'b1;
    cell_wdata.member  = 1'b1;
    cell_wdata.sseen   = 1'b1;
    rl_raddr = head_q[AW-1:0];
    rl_we    = 1'b0;
    rl_waddr = count_q[AW-1:0];
    rl_wdata = {nb_c_q, nb_x_q, nb_y_q};
    sq_raddr = head_q[AW-1:0];
    sq_we    = 1'b0;
    sq_waddr = tail_q[AW-1:0];
    sq_wdata = {nb_c_q, nb_x_q, nb_y_q};
    case (state_q)
      grsf_pkg::ST_IDLE: begin
        cell_raddr = AW'(req_i.cell_index);
        cell_waddr = AW'(req_i.cell_index);
        cell_wdata.movable = req_i.movable;
        if (is_load) begin
          cell_wen.terrain = 1'b1;
          cell_wen.cloth   = 1'b1;
          cell_wen.movable = 1'b1;
        end
      end
      grsf_pkg::ST_CLEAR: begin
        cell_waddr = sweep_q;
        cell_wdata.seen   = 1'b0;
        cell_wdata.member = 1'b0;
        cell_wdata.sseen  = 1'b0;
        cell_wen.seen     = 1'b1;
        cell_wen.member   = 1'b1;
        cell_wen.sseen    = 1'b1;
      end
      grsf_pkg::ST_SCAN_CHK: begin
        cell_waddr = sc_q;
        rl_waddr   = '0;
        rl_wdata   = {sc_q, sx_q, sy_q};
        if (take_scan) begin
          cell_wen.seen   = 1'b1;
          cell_wen.member = 1'b1;
          rl_we           = 1'b1;
        end
      end
      grsf_pkg::ST_GATHER_NB, grsf_pkg::ST_EDGE_NB, grsf_pkg::ST_SPREAD_NB:
        cell_raddr = nb_c_w;
      grsf_pkg::ST_GATHER_NCHK: begin
        if (take_nb) begin
          cell_wen.seen   = 1'b1;
          cell_wen.member = 1'b1;
          rl_we           = 1'b1;
        end
      end
      grsf_pkg::ST_EDGE_LD:   cell_raddr = rl_c;
      grsf_pkg::ST_SPREAD_LD: cell_raddr = sq_c;
      grsf_pkg::ST_EDGE_NCHK: begin
        cell_waddr       = cur_c_q;
        cell_wdata.cloth = cur_t_q;
        sq_wdata         = {cur_c_q, cur_x_q, cur_y_q};
        if (edge_hit) begin
          cell_wen.cloth   = cur_m_q;
          cell_wen.movable = cur_m_q;
          cell_wen.sseen   = 1'b1;
          sq_we            = 1'b1;
        end
      end
      grsf_pkg::ST_SPREAD_NCHK: begin
        cell_wdata.cloth = cr.terrain;
        if (spread_hit) begin
          cell_wen.cloth   = cr.movable;
          cell_wen.movable = cr.movable;
          cell_wen.sseen   = !cr.sseen;
          sq_we            = !cr.sseen;
        end
      end
      grsf_pkg::ST_CLR_WR: begin
        cell_waddr        = rl_c;
        cell_wdata.member = 1'b0;
        cell_wdata.sseen  = 1'b0;
        cell_wen.member   = 1'b1;
        cell_wen.sseen    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= grsf_pkg::ST_IDLE;
      snap_q  <= '0;
      rv_q    <= 1'b0;
      head_q  <= '0;
      count_q <= '0;
      tail_q  <= '0;
      dir_q   <= grsf_pkg::DIR_LEFT;
      sweep_q <= '0;
      oor_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      snap_q  <= snap_d;
      rv_q    <= rv_d;
      head_q  <= head_d;
      count_q <= count_d;
      tail_q  <= tail_d;
      dir_q   <= dir_d;
      sweep_q <= sweep_d;
      oor_q   <= oor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d; h_q <= h_d;
    sx_q <= sx_d; sy_q <= sy_d; sc_q <= sc_d;
    cur_c_q <= cur_c_d; cur_x_q <= cur_x_d; cur_y_q <= cur_y_d;
    nb_c_q <= nb_c_d; nb_x_q <= nb_x_d; nb_y_q <= nb_y_d;
    cur_t_q <= cur_t_d; cur_m_q <= cur_m_d; above_q <= above_d;
    res_q <= res_d;
  end

  assign busy           = (state_q != grsf_pkg::ST_IDLE);
  assign result_valid_o = rv_q;
  assign result_o       = res_q;

  // A result word only follows the closing state of a read or a run.
  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == grsf_pkg::ST_DONE))
    else $error("result word without a finished read or run");

  // Edge and spread cells are distinct region members.
  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == grsf_pkg::ST_SPREAD_POP) |-> (tail_q <= count_q))
    else $error("spread queue longer than the region");

  // The gather pointer never passes the fill point of the region list.
  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == grsf_pkg::ST_GATHER_POP) |-> (head_q <= count_q))
    else $error("region list read beyond its fill");

endmodule

>>> tb/tb_grid_region_slope_flood_fill_unit.sv
// Self-checking testbench for grid_region_slope_flood_fill_unit: directed and random
// load, run and read words against a cycle-free predictor of the slope flood fill.
// Depends on grsf_pkg and the RTL of the unit; reads no files.
module tb_grid_region_slope_flood_fill_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import grsf_pkg::*;

  localparam int unsigned CELLS       = MAX_CELLS_DEF;
  localparam int unsigned SIDE        = MAX_SIDE_DEF;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam logic [1:0]  OP_NONE     = 2'd3;   // unused op code, ignored by the unit

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_word_t    req_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [30:0] cfg_data_i = '0;
  logic        result_valid_o;
  out_word_t   result_o;

  grid_region_slope_flood_fill_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // Free-running clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the configuration registers, masked to their widths.
  logic [6:0]  grid_w_reg;
  logic [6:0]  grid_h_reg;
  logic [30:0] smooth_reg;
  logic [30:0] height_reg;
  logic [12:0] min_region_reg;

  // Mirror of the cell store plus the scratch flags and lists of a run.
  logic signed [31:0] terrain_mem [CELLS];
  logic signed [31:0] cloth_mem   [CELLS];
  bit                 movable_mem [CELLS];
  bit                 written_mem [CELLS];
  bit                 seen_mem    [CELLS];
  bit                 member_mem  [CELLS];
  bit                 sseen_mem   [CELLS];
  int unsigned        region_cells[CELLS];
  int unsigned        spread_cells[CELLS];
  int unsigned        snap_total;

  out_word_t   expected_words[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;

  // ---------------------------------------------------------------------------
  // Predictor of the slope post-processing.
  // ---------------------------------------------------------------------------

  function automatic int unsigned eff_width();
    if (grid_w_reg < 1) return 1;
    if (grid_w_reg > SIDE) return SIDE;
    return grid_w_reg;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = grid_h_reg;
    if (h < 1) h = 1;
    if (h > SIDE) h = SIDE;
    if (eff_width() * h > CELLS) h = CELLS / eff_width();
    return h;
  endfunction

  // Neighbour of cell c, probed left, right, row above, row below.
  function automatic bit neighbour_of(int unsigned c, logic [1:0] dir, int unsigned w,
                                      int unsigned h, output int unsigned n);
    int unsigned x, y;
    x = c % w;
    y = c / w;
    n = 0;
    case (dir)
      DIR_LEFT: begin
        if (x == 0) return 0;
        n = c - 1;
      end
      DIR_RIGHT: begin
        if (x + 1 >= w) return 0;
        n = c + 1;
      end
      DIR_UP: begin
        if (y == 0) return 0;
        n = c - w;
      end
      default: begin
        if (y + 1 >= h) return 0;
        n = c + w;
      end
    endcase
    return 1;
  endfunction

  function automatic longint abs_diff(logic signed [31:0] a, logic signed [31:0] b);
    longint df;
    df = longint'(a) - longint'(b);
    return (df < 0) ? -df : df;
  endfunction

  function automatic bit terrain_close(int unsigned a, int unsigned b);
    return abs_diff(terrain_mem[a], terrain_mem[b]) < longint'(smooth_reg);
  endfunction

  function automatic void snap_cell(int unsigned c);
    if (!movable_mem[c]) return;
    cloth_mem[c]   = terrain_mem[c];
    movable_mem[c] = 0;
    if (snap_total < SNAP_MAX) snap_total++;
  endfunction

  // Edge snapping in list order, then the breadth-first spread from the edge cells.
  function automatic void settle_region(int unsigned count, int unsigned w, int unsigned h);
    int unsigned head, tail, c, n;
    longint above;
    head = 0;
    tail = 0;
    for (int unsigned i = 0; i < count; i++) begin
      c = region_cells[i];
      above = longint'(cloth_mem[c]) - longint'(terrain_mem[c]);
      for (int d = 0; d < 4; d++) begin
        if (!neighbour_of(c, 2'(d), w, h, n) || movable_mem[n]) continue;
        if (terrain_close(c, n) && above < longint'(height_reg)) begin
          snap_cell(c);
          sseen_mem[c] = 1;
          spread_cells[tail++] = c;
          break;
        end
      end
    end
    while (head < tail) begin
      c = spread_cells[head++];
      for (int d = 0; d < 4; d++) begin
        if (!neighbour_of(c, 2'(d), w, h, n) || !member_mem[n]) continue;
        if (terrain_close(c, n) &&
            abs_diff(cloth_mem[n], terrain_mem[n]) < longint'(height_reg)) begin
          // A cell already snapped stays as it is and is not counted again.
          snap_cell(n);
          if (!sseen_mem[n] && tail < CELLS) begin
            sseen_mem[n] = 1;
            spread_cells[tail++] = n;
          end
        end
      end
    end
  endfunction

  function automatic int unsigned predict_snaps();
    int unsigned w, h, start_cell, head, count, c, n;
    w = eff_width();
    h = eff_height();
    foreach (seen_mem[i]) seen_mem[i] = 0;
    snap_total = 0;
    for (int unsigned x = 0; x < w; x++) begin
      for (int unsigned y = 0; y < h; y++) begin
        start_cell = y * w + x;
        if (!movable_mem[start_cell] || seen_mem[start_cell]) continue;
        head = 0;
        count = 0;
        seen_mem[start_cell]   = 1;
        member_mem[start_cell] = 1;
        region_cells[count++]  = start_cell;
        while (head < count) begin
          c = region_cells[head++];
          for (int d = 0; d < 4; d++) begin
            if (!neighbour_of(c, 2'(d), w, h, n)) continue;
            if (movable_mem[n] && !seen_mem[n] && count < CELLS) begin
              seen_mem[n]   = 1;
              member_mem[n] = 1;
              region_cells[count++] = n;
            end
          end
        end
        if (count > min_region_reg) settle_region(count, w, h);
        for (int unsigned i = 0; i < count; i++) begin
          member_mem[region_cells[i]] = 0;
          sseen_mem[region_cells[i]]  = 0;
        end
      end
    end
    return snap_total;
  endfunction

  // Appends one expected word behind the ones already waiting.
  function automatic void add_expected(out_word_t r);
    expected_words.insert(expected_words.size(), r);
  endfunction

  // Applies one accepted word to the mirror and queues the result it causes.
  function automatic void predict_word(in_word_t w);
    out_word_t r;
    r = '0;
    case (w.op)
      OP_LOAD: begin
        terrain_mem[w.cell_index] = w.terrain_height;
        cloth_mem[w.cell_index]   = w.cloth_height;
        movable_mem[w.cell_index] = w.movable;
        written_mem[w.cell_index] = 1;
      end
      OP_RUN: begin
        r.result_kind   = KIND_RUN;
        r.snapped_count = 13'(predict_snaps());
        add_expected(r);
      end
      OP_READ: begin
        r.result_kind  = KIND_READ;
        r.cell_height  = cloth_mem[w.cell_index];
        r.cell_movable = movable_mem[w.cell_index];
        add_expected(r);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every strobed word is held against the oldest expectation.
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("[%0t] error: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", result_o));
      end else begin
        want = expected_words.pop_front();
        if (result_o.result_kind !== want.result_kind)
          report_mismatch($sformatf("result_kind %b, want %b",
                                    result_o.result_kind, want.result_kind));
        if (result_o.cell_height !== want.cell_height)
          report_mismatch($sformatf("cell_height %h, want %h",
                                    result_o.cell_height, want.cell_height));
        if (result_o.cell_movable !== want.cell_movable)
          report_mismatch($sformatf("cell_movable %b, want %b",
                                    result_o.cell_movable, want.cell_movable));
        if (result_o.snapped_count !== want.snapped_count)
          report_mismatch($sformatf("snapped_count %0d, want %0d",
                                    result_o.snapped_count, want.snapped_count));
      end
    end
  end

  // Watchdog: a hung sequencer ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Everything changes at the falling edge; busy is sampled at the rising one.
  // ---------------------------------------------------------------------------

  // Sends one word. The sender works in bursts, so a random gap is usually inserted when
  // a burst runs out; start is left high afterwards so back-to-back words stream.
  task automatic send_word(in_word_t w);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        start = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req_i = w;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    predict_word(w);
    @(negedge clk_i);
  endtask

  // Waits until every expected word is back. Loads give no result, so a few spare
  // cycles follow to let the last one land before the caller touches the registers.
  task automatic drain();
    start = 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [30:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_GRID_WIDTH:  grid_w_reg     = data[6:0];
      CFG_GRID_HEIGHT: grid_h_reg     = data[6:0];
      CFG_SMOOTH_THR:  smooth_reg     = data;
      CFG_HEIGHT_THR:  height_reg     = data;
      CFG_MIN_REGION:  min_region_reg = data[12:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned w, int unsigned h, int unsigned smooth,
                            int unsigned height, int unsigned min_region);
    drain();
    write_reg(CFG_GRID_WIDTH, 31'(w));
    write_reg(CFG_GRID_HEIGHT, 31'(h));
    write_reg(CFG_SMOOTH_THR, 31'(smooth));
    write_reg(CFG_HEIGHT_THR, 31'(height));
    write_reg(CFG_MIN_REGION, 31'(min_region));
  endtask

  // Terrain on quarter-unit steps, so neighbours are often within the default smooth
  // limit; cloth hangs a little above or below. Now and then anything goes.
  function automatic in_word_t cell_load(int unsigned idx);
    in_word_t w;
    w.op         = OP_LOAD;
    w.cell_index = 12'(idx);
    w.movable    = ($urandom_range(0, 9) < 7);
    if ($urandom_range(0, 9) == 0) begin
      w.terrain_height = $urandom;
      w.cloth_height   = $urandom;
    end else begin
      w.terrain_height = $signed($urandom_range(0, 3) * 16384) - 32768;
      w.cloth_height   = w.terrain_height + $signed($urandom_range(0, 5 * 65536)) - 98304;
    end
    return w;
  endfunction

  function automatic in_word_t plain_word(logic [1:0] op, int unsigned idx);
    in_word_t w;
    w = '0;
    w.op = op;
    w.cell_index = 12'(idx);
    return w;
  endfunction

  // A run reads every cell of the grid, so any cell not yet written is loaded first.
  task automatic fill_grid();
    for (int unsigned i = 0; i < eff_width() * eff_height(); i++)
      if (!written_mem[i]) send_word(cell_load(i));
  endtask

  // Read index: a cell of the grid, or now and then a written cell high in the store.
  function automatic int unsigned read_index();
    int unsigned idx;
    idx = $urandom_range(0, eff_width() * eff_height() - 1);
    if ($urandom_range(0, 9) == 0) begin
      for (int k = 0; k < 8; k++) begin
        if (written_mem[CELLS - 1 - k]) return CELLS - 1 - k;
      end
    end
    return idx;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every op and the small-grid corner cases.
  task automatic test_directed();
    in_word_t w;
    set_config(4, 4, 31'd19661, 31'd65536, 0);
    for (int unsigned i = 0; i < 16; i++) send_word(cell_load(i));
    // Extreme heights at the top of the store, then read them back.
    w = cell_load(CELLS - 1);
    w.terrain_height = 32'sh7FFF_FFFF;
    w.cloth_height   = 32'sh8000_0000;
    w.movable        = 1'b1;
    send_word(w);
    w = cell_load(CELLS - 2);
    w.terrain_height = 32'sh8000_0000;
    w.cloth_height   = 32'sh7FFF_FFFF;
    w.movable        = 1'b0;
    send_word(w);
    send_word(plain_word(OP_READ, CELLS - 1));
    send_word(plain_word(OP_READ, CELLS - 2));
    // The unused op code produces nothing.
    w = cell_load(2048);
    w.op = OP_NONE;
    send_word(w);
    send_word(plain_word(OP_RUN, 0));
    for (int unsigned i = 0; i < 16; i += 3) send_word(plain_word(OP_READ, i));
    send_word(plain_word(OP_RUN, 0));
    // Zero width and height fold to a single cell.
    set_config(0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
    send_word(cell_load(0));
    send_word(plain_word(OP_RUN, 0));
    send_word(plain_word(OP_READ, 0));
  endtask

  // Oversized registers fold to the largest side: one full-width row, then one
  // full-height column over the same cells.
  task automatic test_grid_clamp();
    set_config(127, 1, 31'd19661, 31'd655294464, 0);
    fill_grid();
    send_word(plain_word(OP_RUN, 0));
    repeat (6) send_word(plain_word(OP_READ, read_index()));
    set_config(1, 127, 31'd19661, 31'd655294464, 0);
    fill_grid();
    send_word(plain_word(OP_RUN, 0));
    drain();
    write_reg(CFG_MIN_REGION, 31'd4096);
    send_word(plain_word(OP_RUN, 0));
  endtask

  // Phases of random settings on small grids with a mix of loads, reads, runs and unused op words.
  task automatic test_random_phases();
    logic [30:0] smooth, height;
    int unsigned pick;
    for (int phase = 0; phase < 14; phase++) begin
      case ($urandom_range(0, 3))
        0: smooth = 31'd0;
        1: smooth = 31'h7FFF_FFFF;
        2: smooth = 31'($urandom);
        default: smooth = 31'd19661 + 31'($urandom_range(0, 20000));
      endcase
      case ($urandom_range(0, 3))
        0: height = 31'd0;
        1: height = 31'h7FFF_FFFF;
        2: height = 31'($urandom);
        default: height = 31'($urandom_range(0, 4 * 65536));
      endcase
      set_config($urandom_range(1, 10), $urandom_range(1, 10), smooth, height,
                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 8191) : $urandom_range(0, 5));
      fill_grid();
      repeat (45) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          send_word(cell_load($urandom_range(0, 9) == 0 ? $urandom_range(2048, CELLS - 1)
                                                        : read_index()));
        end else if (pick < 78) begin
          send_word(plain_word(OP_READ, read_index()));
        end else if (pick < 95) begin
          send_word(plain_word(OP_RUN, 0));
        end else begin
          send_word(plain_word(OP_NONE, $urandom_range(0, CELLS - 1)));
        end
      end
      send_word(plain_word(OP_RUN, 0));
    end
  endtask

  initial begin
    grid_w_reg     = RST_GRID_WIDTH;
    grid_h_reg     = RST_GRID_HEIGHT;
    smooth_reg     = RST_SMOOTH_THR;
    height_reg     = RST_HEIGHT_THR;
    min_region_reg = RST_MIN_REGION;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_phases();
    test_grid_clamp();
    drain();
    repeat (20) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/grsf_pkg.sv
hw/rtl/grsf_cell_store.sv
hw/rtl/grid_region_slope_flood_fill_unit.sv
tb/tb_grid_region_slope_flood_fill_unit.sv
